### design/tccw_pkg.sv
`default_nettype none

package tccw_pkg;

    // Grid geometry defaults
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths fixed by the interface
    localparam int CHAR_W   = 8;
    localparam int ADDR_W   = 11;
    localparam int CELL_W   = 16;
    localparam int COLOR_W  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 4;

    // Depth of the command and result queues
    localparam int QUEUE_DEPTH = 2;

    // Cell written into a freshly scrolled-in row
    localparam logic [CELL_W-1:0] FILL_CELL = 16'h0F00;

    // Tab stops every eight columns
    localparam int TAB_STEP = 8;
    localparam int TAB_MASK = TAB_STEP - 1;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    // Operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_BG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASKED_BG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_CHAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_DIS  = 3'd5;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    // Command class decided by the front end
    typedef enum logic [2:0] {
        K_READ,
        K_CHAR,
        K_BS,
        K_TAB,
        K_CR,
        K_LF
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  char_code;
        logic [ADDR_W-1:0]  read_address;
    } t_cmd;

    typedef struct packed {
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic               reverse_background;
        logic               masked_background;
        logic               keep_character;
        logic               scroll_disabled;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0]  cursor_position;
        logic [CELL_W-1:0]  cell_value;
        logic               cell_written;
        logic               scrolled;
        logic               offscreen;
    } t_result;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_SCROLL,
        ST_FILL
    } t_back_state;

endpackage

`default_nettype wire

### design/tccw_fifo.sv
`default_nettype none

module tccw_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = tccw_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_data[r_rd_ptr];

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNTW'(1);
            2'b01:   n_count = r_count - CNTW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### design/tccw_front.sv
`default_nettype none

module tccw_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire logic                            i_hold,
    input  wire logic                            i_op,
    input  wire logic [tccw_pkg::CHAR_W-1:0]     i_char_code,
    input  wire logic [tccw_pkg::ADDR_W-1:0]     i_read_address,
    output logic                                 o_full,
    output tccw_pkg::t_cmd                       o_cmd,
    output logic                                 o_cmd_valid,
    input  wire logic                            i_cmd_pop
);

    localparam int CMD_W = $bits(tccw_pkg::t_cmd);

    tccw_pkg::t_cmd   cmd_in;
    logic             q_full, q_empty;
    logic [CMD_W-1:0] q_data;

    // Classify the incoming byte
    always_comb begin
        cmd_in.char_code    = i_char_code;
        cmd_in.read_address = i_read_address;
        if (i_op == tccw_pkg::OP_READ) begin
            cmd_in.kind = tccw_pkg::K_READ;
        end else begin
            unique case (i_char_code)
                tccw_pkg::CH_BS:  cmd_in.kind = tccw_pkg::K_BS;
                tccw_pkg::CH_TAB: cmd_in.kind = tccw_pkg::K_TAB;
                tccw_pkg::CH_CR:  cmd_in.kind = tccw_pkg::K_CR;
                tccw_pkg::CH_LF:  cmd_in.kind = tccw_pkg::K_LF;
                default:          cmd_in.kind = tccw_pkg::K_CHAR;
            endcase
        end
    end

    // Input refused while the queue is full or the grid is being cleared
    assign o_full = q_full || i_hold;

    tccw_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (tccw_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (i_cmd_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign o_cmd       = tccw_pkg::t_cmd'(q_data);
    assign o_cmd_valid = !q_empty;

endmodule

`default_nettype wire

### design/tccw_back.sv
`default_nettype none

module tccw_back #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire tccw_pkg::t_cfg i_cfg,
    input  wire tccw_pkg::t_cmd i_cmd,
    input  wire logic       i_cmd_valid,
    output logic            o_cmd_pop,
    input  wire logic       i_res_full,
    output logic            o_res_push,
    output tccw_pkg::t_result o_res,
    output logic            o_clearing
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int AW     = $clog2(CELLS);
    localparam int COLW   = $clog2(COLUMNS);
    localparam int CTW    = $clog2(COLUMNS + tccw_pkg::TAB_STEP);
    localparam int RW     = $clog2(ROWS + 1);
    localparam int N_MOVE = COLUMNS * (ROWS - 1);
    localparam int CW     = tccw_pkg::CELL_W;

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] MOVE_END  = AW'(N_MOVE);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);

    function automatic logic [31:0] lin_index(input logic [RW-1:0] row,
                                              input logic [COLW-1:0] col);
        lin_index = 32'(row) * 32'(COLUMNS) + 32'(col);
    endfunction

    // Sequencer and cursor state
    tccw_pkg::t_back_state r_state, n_state;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic [COLW-1:0] r_col, n_col;
    logic [RW-1:0]   r_row, n_row;

    // Per-item payload
    logic [AW-1:0]   r_idx, n_idx;
    logic [7:0]      r_char, n_char;
    logic            r_rd_ok, n_rd_ok;
    logic            r_scroll, n_scroll;
    logic [CW-1:0]   r_value, n_value;
    logic            r_written, n_written;

    // Cell memory
    logic [CW-1:0]   r_mem [CELLS];
    logic [CW-1:0]   r_mem_q;
    logic            mem_re, mem_we;
    logic [AW-1:0]   mem_raddr, mem_waddr;
    logic [CW-1:0]   mem_wdata;

    // Cursor step
    logic [CTW-1:0]  step_col;
    logic [RW-1:0]   step_row;
    logic            step_scroll;
    logic [COLW-1:0] move_col;
    logic [RW-1:0]   move_row;
    logic            offscreen_now;

    logic [31:0]     cur_lin, addr32, pos32;
    logic [AW-1:0]   cur_idx, addr_idx;
    logic            addr_ok;

    logic [3:0]      old_bg, new_bg;
    logic [7:0]      new_ch;
    logic [CW-1:0]   new_cell;

    logic [CW-1:0]   res_value;
    logic            res_written, res_scrolled, res_offscreen;

    // Cursor movement for a put command
    always_comb begin
        step_col = CTW'(r_col);
        step_row = r_row;
        unique case (i_cmd.kind)
            tccw_pkg::K_BS: begin
                if (r_col != '0) begin
                    step_col = CTW'(r_col) - CTW'(1);
                end
            end
            tccw_pkg::K_TAB: begin
                step_col = (CTW'(r_col) + CTW'(tccw_pkg::TAB_STEP))
                           & ~CTW'(tccw_pkg::TAB_MASK);
            end
            tccw_pkg::K_CR: step_col = '0;
            tccw_pkg::K_LF: begin
                step_col = '0;
                step_row = r_row + RW'(1);
            end
            tccw_pkg::K_CHAR: step_col = CTW'(r_col) + CTW'(1);
            default: step_col = CTW'(r_col);
        endcase
        // wrap past the last column
        if (step_col >= CTW'(COLUMNS)) begin
            step_col = '0;
            step_row = step_row + RW'(1);
        end
        step_scroll = (step_row >= RW'(ROWS)) && !i_cfg.scroll_disabled;
        move_row    = step_scroll ? RW'(ROWS - 1) : step_row;
        move_col    = step_col[COLW-1:0];
    end

    assign offscreen_now = (r_row >= RW'(ROWS));
    assign cur_lin  = lin_index(r_row, r_col);
    assign cur_idx  = cur_lin[AW-1:0];
    assign addr32   = 32'(i_cmd.read_address);
    assign addr_ok  = (addr32 < 32'(CELLS));
    assign addr_idx = addr32[AW-1:0];

    // New cell from the old one and the color settings
    always_comb begin
        old_bg = r_mem_q[15:12];
        new_bg = i_cfg.bg_color;
        if (i_cfg.reverse_background) begin
            new_bg = 4'hF - old_bg;
        end else if (i_cfg.masked_background && (i_cfg.bg_color == 4'h0)) begin
            new_bg = old_bg;
        end
        new_ch   = i_cfg.keep_character ? r_mem_q[7:0] : r_char;
        new_cell = {new_bg, i_cfg.fg_color, new_ch};
    end

    // Sequencer: next state, memory control, result push
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_col     = r_col;
        n_row     = r_row;
        n_idx     = r_idx;
        n_char    = r_char;
        n_rd_ok   = r_rd_ok;
        n_scroll  = r_scroll;
        n_value   = r_value;
        n_written = r_written;

        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = '0;
        mem_waddr = '0;
        mem_wdata = '0;

        o_cmd_pop     = 1'b0;
        o_res_push    = 1'b0;
        res_value     = '0;
        res_written   = 1'b0;
        res_scrolled  = 1'b0;
        res_offscreen = 1'b0;

        unique case (r_state)
            tccw_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                if (r_cnt == LAST_CELL) begin
                    n_cnt   = '0;
                    n_state = tccw_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end

            tccw_pkg::ST_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    priority if (i_cmd.kind == tccw_pkg::K_READ) begin
                        mem_re    = addr_ok;
                        mem_raddr = addr_idx;
                        n_rd_ok   = addr_ok;
                        n_state   = tccw_pkg::ST_READ;
                    end else if (offscreen_now) begin
                        o_res_push    = 1'b1;
                        res_offscreen = 1'b1;
                    end else begin
                        n_col     = move_col;
                        n_row     = move_row;
                        n_scroll  = step_scroll;
                        n_value   = '0;
                        n_written = 1'b0;
                        if (i_cmd.kind == tccw_pkg::K_CHAR) begin
                            mem_re    = 1'b1;
                            mem_raddr = cur_idx;
                            n_idx     = cur_idx;
                            n_char    = i_cmd.char_code;
                            n_state   = tccw_pkg::ST_WRITE;
                        end else if (step_scroll) begin
                            n_cnt   = '0;
                            n_state = tccw_pkg::ST_SCROLL;
                        end else begin
                            o_res_push = 1'b1;
                        end
                    end
                end
            end

            tccw_pkg::ST_READ: begin
                o_res_push = 1'b1;
                res_value  = r_rd_ok ? r_mem_q : '0;
                n_state    = tccw_pkg::ST_IDLE;
            end

            tccw_pkg::ST_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = new_cell;
                n_value   = new_cell;
                n_written = 1'b1;
                if (r_scroll) begin
                    n_cnt   = '0;
                    n_state = tccw_pkg::ST_SCROLL;
                end else begin
                    o_res_push  = 1'b1;
                    res_value   = new_cell;
                    res_written = 1'b1;
                    n_state     = tccw_pkg::ST_IDLE;
                end
            end

            // move rows up: read one row below, write it back in the following cycle
            tccw_pkg::ST_SCROLL: begin
                mem_re    = (r_cnt != MOVE_END);
                mem_raddr = r_cnt + ROW_STEP;
                mem_we    = (r_cnt != '0);
                mem_waddr = r_cnt - AW'(1);
                mem_wdata = r_mem_q;
                if (r_cnt == MOVE_END) begin
                    n_state = tccw_pkg::ST_FILL;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end

            // blank the new bottom row
            tccw_pkg::ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = tccw_pkg::FILL_CELL;
                if (r_cnt == LAST_CELL) begin
                    o_res_push   = 1'b1;
                    res_value    = r_value;
                    res_written  = r_written;
                    res_scrolled = 1'b1;
                    n_cnt        = '0;
                    n_state      = tccw_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end

            default: n_state = tccw_pkg::ST_IDLE;
        endcase
    end

    // Result word
    assign pos32 = lin_index(n_row, n_col);
    always_comb begin
        o_res.cursor_position = pos32[tccw_pkg::ADDR_W-1:0];
        o_res.cell_value      = res_value;
        o_res.cell_written    = res_written;
        o_res.scrolled        = res_scrolled;
        o_res.offscreen       = res_offscreen;
    end

    assign o_clearing = (r_state == tccw_pkg::ST_CLEAR);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tccw_pkg::ST_CLEAR;
            r_cnt   <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_char    <= n_char;
        r_rd_ok   <= n_rd_ok;
        r_scroll  <= n_scroll;
        r_value   <= n_value;
        r_written <= n_written;
    end

    // Cell memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

### design/text_console_char_writer_core.sv
// Path, transfer in to result visible: command queue, back end, result queue; a
// printable character or a cell read also passes a registered cell-memory read.
// Throughput: one item per cycle for control characters while the result queue has room;
// a printable character or a read holds the back end in a second state (read-modify-write);
// a scroll adds a row move, then a bottom-row fill, before the next command is taken.
// Reset (synchronous): a clearing pass over all COLUMNS*ROWS cells holds full high.
`default_nettype none

module text_console_char_writer_core #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // item input
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic                               i_op,
    input  wire logic [tccw_pkg::CHAR_W-1:0]        i_char_code,
    input  wire logic [tccw_pkg::ADDR_W-1:0]        i_read_address,
    // result output
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [tccw_pkg::ADDR_W-1:0]             o_cursor_position,
    output logic [tccw_pkg::CELL_W-1:0]             o_cell_value,
    output logic                                    o_cell_written,
    output logic                                    o_scrolled,
    output logic                                    o_offscreen,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [tccw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tccw_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int RES_W = $bits(tccw_pkg::t_result);

    tccw_pkg::t_cfg    r_cfg;
    tccw_pkg::t_cmd    cmd;
    tccw_pkg::t_result res_in, res_out;
    logic              cmd_valid, cmd_pop;
    logic              res_push, out_full, clearing;
    logic [RES_W-1:0]  out_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fg_color           <= tccw_pkg::FG_RESET;
            r_cfg.bg_color           <= tccw_pkg::BG_RESET;
            r_cfg.reverse_background <= 1'b0;
            r_cfg.masked_background  <= 1'b0;
            r_cfg.keep_character     <= 1'b0;
            r_cfg.scroll_disabled    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tccw_pkg::CFG_FG_COLOR:   r_cfg.fg_color           <= i_cfg_data;
                tccw_pkg::CFG_BG_COLOR:   r_cfg.bg_color           <= i_cfg_data;
                tccw_pkg::CFG_REVERSE_BG: r_cfg.reverse_background <= i_cfg_data[0];
                tccw_pkg::CFG_MASKED_BG:  r_cfg.masked_background  <= i_cfg_data[0];
                tccw_pkg::CFG_KEEP_CHAR:  r_cfg.keep_character     <= i_cfg_data[0];
                tccw_pkg::CFG_SCROLL_DIS: r_cfg.scroll_disabled    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front end: classify and queue commands
    tccw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_hold         (clearing),
        .i_op           (i_op),
        .i_char_code    (i_char_code),
        .i_read_address (i_read_address),
        .o_full         (full),
        .o_cmd          (cmd),
        .o_cmd_valid    (cmd_valid),
        .i_cmd_pop      (cmd_pop)
    );

    // Back end: cursor, cell memory, scroll sequencer
    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (out_full),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .o_clearing  (clearing)
    );

    // Result queue
    tccw_fifo #(
        .WIDTH (RES_W),
        .DEPTH (tccw_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign res_out           = tccw_pkg::t_result'(out_data);
    assign o_cursor_position = res_out.cursor_position;
    assign o_cell_value      = res_out.cell_value;
    assign o_cell_written    = res_out.cell_written;
    assign o_scrolled        = res_out.scrolled;
    assign o_offscreen       = res_out.offscreen;

    // A command is taken only with room reserved for its result
    a_pop_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !out_full)
        else $error("command taken while result queue full");

    // No command leaves the queue during the clearing pass
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (full && !cmd_pop && !res_push))
        else $error("activity during clearing pass");

    // An ignored put carries no cell and no scroll
    a_offscreen_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_offscreen) |-> (!o_cell_written && !o_scrolled
                                     && (o_cell_value == '0)))
        else $error("offscreen result carries cell data");

endmodule

`default_nettype wire

### bench/text_console_char_writer_core_tb.sv
module text_console_char_writer_core_tb;

    localparam int COLS           = tccw_pkg::COLUMNS_DEF;
    localparam int ROWS           = tccw_pkg::ROWS_DEF;
    localparam int CELLS          = COLS * ROWS;
    localparam int IDLE_LIMIT     = 20000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int PHASE_ITEMS    = 70;
    localparam int CW             = tccw_pkg::CELL_W;
    localparam int AW             = tccw_pkg::ADDR_W;
    localparam int CHW            = tccw_pkg::CHAR_W;
    localparam int CLW            = tccw_pkg::COLOR_W;
    localparam int IXW            = tccw_pkg::CFG_IDX_W;
    localparam int DW             = tccw_pkg::CFG_DAT_W;
    // register slots past the end of the map; writes there must be dropped
    localparam logic [IXW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [IXW-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic           op;
        logic [CHW-1:0] char_code;
        logic [AW-1:0]  read_address;
    } t_tty_item;

    logic           i_clk;
    logic           i_rst_n        = 1'b0;
    logic           push           = 1'b0;
    logic           full;
    logic           i_op           = tccw_pkg::OP_PUT;
    logic [CHW-1:0] i_char_code    = '0;
    logic [AW-1:0]  i_read_address = '0;
    logic           empty;
    logic           pop            = 1'b0;
    logic [AW-1:0]  o_cursor_position;
    logic [CW-1:0]  o_cell_value;
    logic           o_cell_written;
    logic           o_scrolled;
    logic           o_offscreen;
    logic           i_cfg_we       = 1'b0;
    logic [IXW-1:0] i_cfg_index    = '0;
    logic [DW-1:0]  i_cfg_data     = '0;

    text_console_char_writer_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_op              (i_op),
        .i_char_code       (i_char_code),
        .i_read_address    (i_read_address),
        .empty             (empty),
        .pop               (pop),
        .o_cursor_position (o_cursor_position),
        .o_cell_value      (o_cell_value),
        .o_cell_written    (o_cell_written),
        .o_scrolled        (o_scrolled),
        .o_offscreen       (o_offscreen),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Shadow of the console: screen, cursor and color registers
    logic [CW-1:0]  screen_model [CELLS];
    int             cur_col = 0;
    int             cur_row = 0;
    logic [CLW-1:0] cfg_fg = tccw_pkg::FG_RESET;
    logic [CLW-1:0] cfg_bg = tccw_pkg::BG_RESET;
    logic           cfg_reverse    = 1'b0;
    logic           cfg_masked     = 1'b0;
    logic           cfg_keep       = 1'b0;
    logic           cfg_scroll_off = 1'b0;

    t_tty_item         tty_input_q[$];
    tccw_pkg::t_result tty_result_q[$];
    int                mismatch_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one console byte or cell read to the shadow and queue the outcome
    function automatic void predict_tty_step(input logic op, input logic [CHW-1:0] ch,
                                             input logic [AW-1:0] addr);
        tccw_pkg::t_result r;
        int                idx;
        int                pos;
        int                k;
        logic [CW-1:0]     old_cell;
        logic [CLW-1:0]    bg;
        logic [CHW-1:0]    glyph;
        r = '0;
        if (op == tccw_pkg::OP_READ) begin
            if (addr < CELLS)
                r.cell_value = screen_model[addr];
        end else if (cur_row >= ROWS) begin
            r.offscreen = 1'b1;
        end else begin
            case (ch)
                tccw_pkg::CH_BS: begin
                    if (cur_col != 0)
                        cur_col--;
                end
                tccw_pkg::CH_TAB: cur_col = (cur_col + tccw_pkg::TAB_STEP) & ~tccw_pkg::TAB_MASK;
                tccw_pkg::CH_CR:  cur_col = 0;
                tccw_pkg::CH_LF: begin
                    cur_col = 0;
                    cur_row++;
                end
                default: begin
                    idx      = cur_row * COLS + cur_col;
                    old_cell = screen_model[idx];
                    bg       = cfg_bg;
                    // reverse wins over masked
                    if (cfg_reverse)
                        bg = 4'hF - old_cell[15:12];
                    else if (cfg_masked && bg == '0)
                        bg = old_cell[15:12];
                    glyph = cfg_keep ? old_cell[7:0] : ch;
                    screen_model[idx] = {bg, cfg_fg, glyph};
                    r.cell_value   = screen_model[idx];
                    r.cell_written = 1'b1;
                    cur_col++;
                end
            endcase
            if (cur_col >= COLS) begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= ROWS && !cfg_scroll_off) begin
                for (k = 0; k < CELLS - COLS; k++)
                    screen_model[k] = screen_model[k + COLS];
                for (k = CELLS - COLS; k < CELLS; k++)
                    screen_model[k] = tccw_pkg::FILL_CELL;
                cur_row    = ROWS - 1;
                r.scrolled = 1'b1;
            end
        end
        pos = cur_row * COLS + cur_col;
        r.cursor_position = pos[AW-1:0];
        tty_result_q.push_back(r);
    endfunction

    function automatic t_tty_item tty_item(input logic op, input logic [CHW-1:0] ch,
                                           input logic [AW-1:0] addr);
        t_tty_item it;
        it.op           = op;
        it.char_code    = ch;
        it.read_address = addr;
        return it;
    endfunction

    // Mostly text with a healthy share of line feeds so the screen scrolls often
    function automatic t_tty_item random_tty_item();
        t_tty_item   it;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        it.op           = tccw_pkg::OP_PUT;
        it.char_code    = CHW'($urandom_range(0, 255));
        it.read_address = AW'($urandom_range(0, 2047));
        if (sel < 5) begin
            it.op           = tccw_pkg::OP_READ;
            it.read_address = AW'($urandom_range(CELLS - 5 * COLS, CELLS - 1));
        end else if (sel < 11)
            it.op = tccw_pkg::OP_READ;
        else if (sel < 25)
            it.char_code = tccw_pkg::CH_LF;
        else if (sel < 30)
            it.char_code = tccw_pkg::CH_TAB;
        else if (sel < 35)
            it.char_code = tccw_pkg::CH_BS;
        else if (sel < 39)
            it.char_code = tccw_pkg::CH_CR;
        return it;
    endfunction

    // One-bit registers get random upper data bits, which must be ignored
    function automatic logic [DW-1:0] flag_data(input logic b);
        logic [DW-1:0] d;
        d    = DW'($urandom_range(0, 15));
        d[0] = b;
        return d;
    endfunction

    task automatic write_cfg_reg(input logic [IXW-1:0] idx,
                                 input logic [DW-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            tccw_pkg::CFG_FG_COLOR:   cfg_fg         = data;
            tccw_pkg::CFG_BG_COLOR:   cfg_bg         = data;
            tccw_pkg::CFG_REVERSE_BG: cfg_reverse    = data[0];
            tccw_pkg::CFG_MASKED_BG:  cfg_masked     = data[0];
            tccw_pkg::CFG_KEEP_CHAR:  cfg_keep       = data[0];
            tccw_pkg::CFG_SCROLL_DIS: cfg_scroll_off = data[0];
            default: ;
        endcase
    endtask

    task automatic program_console(input logic [CLW-1:0] fg, input logic [CLW-1:0] bg,
                                   input logic rev, input logic masked, input logic keep,
                                   input logic scroll_off);
        write_cfg_reg(tccw_pkg::CFG_FG_COLOR, fg);
        write_cfg_reg(CFG_SPARE_LO, DW'($urandom_range(0, 15)));
        write_cfg_reg(tccw_pkg::CFG_BG_COLOR, bg);
        write_cfg_reg(tccw_pkg::CFG_REVERSE_BG, flag_data(rev));
        write_cfg_reg(tccw_pkg::CFG_MASKED_BG, flag_data(masked));
        write_cfg_reg(CFG_SPARE_HI, DW'($urandom_range(0, 15)));
        write_cfg_reg(tccw_pkg::CFG_KEEP_CHAR, flag_data(keep));
        write_cfg_reg(tccw_pkg::CFG_SCROLL_DIS, flag_data(scroll_off));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait for every queued byte and result, then let a trailing scroll finish
    task automatic wait_tty_drained(input int settle_cycles);
        while (tty_input_q.size() != 0 || push || tty_result_q.size() != 0)
            @(negedge i_clk);
        repeat (settle_cycles) @(posedge i_clk);
    endtask

    // Driver: bursts of transfers separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : tty_driver
        logic accepted;
        logic next_push;
        if (!i_rst_n) begin
            push       <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            accepted = push && !full;
            if (accepted) begin
                predict_tty_step(i_op, i_char_code, i_read_address);
                void'(tty_input_q.pop_front());
                if (burst_left > 0)
                    burst_left--;
            end
            // an offered item is held until it transfers
            if (!(push && !accepted)) begin
                next_push = 1'b0;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0)
                    gap_left--;
                else if (tty_input_q.size() != 0) begin
                    next_push      = 1'b1;
                    i_op           <= tty_input_q[0].op;
                    i_char_code    <= tty_input_q[0].char_code;
                    i_read_address <= tty_input_q[0].read_address;
                end
                push <= next_push;
            end
        end
    end

    // Receiver: rotating stall pattern plus one long hold-off to back up the block
    logic [7:0] stall_pattern = 8'hFF;
    int         pattern_age   = 0;
    int         results_taken = 0;
    int         holdoff_left  = 0;
    logic       holdoff_done  = 1'b0;

    always @(posedge i_clk) begin : tty_receiver
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                results_taken++;
            if (!holdoff_done && results_taken >= 150 && tty_input_q.size() > 16) begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                pop <= 1'b0;
            end else begin
                if (pattern_age == 0) begin
                    pattern_age   = $urandom_range(16, 64);
                    stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF
                                                               : 8'($urandom | $urandom);
                end
                pattern_age--;
                pop           <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Monitor: every result transfer is matched to the oldest prediction
    always @(posedge i_clk) begin : tty_monitor
        tccw_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (tty_result_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual pos %0h cell %0h",
                         $time, o_cursor_position, o_cell_value);
                mismatch_count++;
            end else begin
                want = tty_result_q.pop_front();
                check_field("cursor_position", 32'(want.cursor_position),
                            32'(o_cursor_position));
                check_field("cell_value", 32'(want.cell_value), 32'(o_cell_value));
                check_field("cell_written", 32'(want.cell_written), 32'(o_cell_written));
                check_field("scrolled", 32'(want.scrolled), 32'(o_scrolled));
                check_field("offscreen", 32'(want.offscreen), 32'(o_offscreen));
            end
        end
    end

    // Watchdog on cycles without any transfer
    int idle_cycles = 0;

    always @(posedge i_clk) begin : tty_watchdog
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus
    initial begin : tty_stimulus
        int             phase;
        int             n;
        logic [CLW-1:0] fg;
        logic [CLW-1:0] bg;
        logic           rev;
        logic           masked;
        logic           keep;
        foreach (screen_model[k])
            screen_model[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, control bytes, tab wrap, reads in and out of range
        @(negedge i_clk);
        tty_input_q.push_back(tty_item(tccw_pkg::OP_PUT, 8'h48, 11'h7FF));
        tty_input_q.push_back(tty_item(tccw_pkg::OP_PUT, 8'h00, '0));
        tty_input_q.push_back(tty_item(tccw_pkg::OP_PUT, 8'hFF, '0));
        repeat (4) tty_input_q.push_back(tty_item(tccw_pkg::OP_PUT, tccw_pkg::CH_BS, '0));
        tty_input_q.push_back(tty_item(tccw_pkg::OP_READ, 8'hFF, 11'd0));
        tty_input_q.push_back(tty_item(tccw_pkg::OP_READ, '0, 11'd2));
        tty_input_q.push_back(tty_item(tccw_pkg::OP_READ, '0, AW'(CELLS - 1)));
        tty_input_q.push_back(tty_item(tccw_pkg::OP_READ, '0, AW'(CELLS)));
        tty_input_q.push_back(tty_item(tccw_pkg::OP_READ, '0, 11'h7FF));
        // ten tabs run off the end of the row
        repeat (10) tty_input_q.push_back(tty_item(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, '0));
        tty_input_q.push_back(tty_item(tccw_pkg::OP_PUT, tccw_pkg::CH_CR, '0));
        tty_input_q.push_back(tty_item(tccw_pkg::OP_PUT, tccw_pkg::CH_LF, '0));
        tty_input_q.push_back(tty_item(tccw_pkg::OP_PUT, 8'h7F, '0));
        wait_tty_drained(CELLS + 16);

        // random phases, each under its own color mode
        for (phase = 0; phase < 8; phase++) begin
            fg     = CLW'($urandom_range(0, 15));
            bg     = CLW'($urandom_range(0, 15));
            rev    = 1'($urandom_range(0, 1));
            masked = 1'($urandom_range(0, 1));
            keep   = 1'($urandom_range(0, 1));
            case (phase)
                0: program_console(4'hF, 4'hF, 1'b0, 1'b0, 1'b0, 1'b0);
                1: program_console(4'h0, 4'h0, 1'b0, 1'b1, 1'b0, 1'b0);
                2: program_console(fg, bg, 1'b1, 1'b1, 1'b0, 1'b0);
                3: program_console(fg, 4'h0, 1'b0, 1'b1, 1'b1, 1'b0);
                4: program_console(4'hF, 4'h0, 1'b1, 1'b0, 1'b1, 1'b0);
                default: program_console(fg, bg, rev, masked, keep, 1'b0);
            endcase
            @(negedge i_clk);
            for (n = 0; n < PHASE_ITEMS; n++)
                tty_input_q.push_back(random_tty_item());
            wait_tty_drained(CELLS + 16);
        end

        // scrolling off: run the cursor below the screen, then puts are dropped
        program_console(CLW'($urandom_range(0, 15)), CLW'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'b1);
        @(negedge i_clk);
        for (n = 0; n < 15; n++)
            tty_input_q.push_back(random_tty_item());
        repeat (30) tty_input_q.push_back(tty_item(tccw_pkg::OP_PUT, tccw_pkg::CH_LF,
                                                   AW'($urandom_range(0, 2047))));
        for (n = 0; n < 40; n++)
            tty_input_q.push_back(random_tty_item());
        wait_tty_drained(20);

        if (mismatch_count == 0 && tty_result_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
